/* rtl/tvs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tvs_pkg;
    localparam int unsigned POS_W = 32;
    localparam int unsigned INV_W = 24;
    localparam int unsigned INV_FRAC = 16;
    localparam int unsigned RES_W = 7;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned VALUE_WIDTH = 32;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic [2:0] REG_INV_X = 3'd0;
    localparam logic [2:0] REG_INV_Y = 3'd1;
    localparam logic [2:0] REG_INV_Z = 3'd2;
    localparam logic [2:0] REG_RES_X = 3'd3;
    localparam logic [2:0] REG_RES_Y = 3'd4;
    localparam logic [2:0] REG_RES_Z = 3'd5;

    // Configuration register set.
    typedef struct packed {
        logic [INV_W-1:0] inv_x;
        logic [INV_W-1:0] inv_y;
        logic [INV_W-1:0] inv_z;
        logic [RES_W-1:0] res_x;
        logic [RES_W-1:0] res_y;
        logic [RES_W-1:0] res_z;
    } t_cfg;
endpackage
`default_nettype wire

/* rtl/tvs_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface tvs_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [5:0]  sample_x;
    logic [5:0]  sample_y;
    logic [5:0]  sample_z;
    logic [31:0] sample_value;
    modport source (output valid, op, pos_x, pos_y, pos_z, sample_x, sample_y,
                    sample_z, sample_value, input ready);
    modport sink (input valid, op, pos_x, pos_y, pos_z, sample_x, sample_y,
                  sample_z, sample_value, output ready);
endinterface

interface tvs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] interp_value;
    modport source (output valid, interp_value, input ready);
    modport sink (input valid, interp_value, output ready);
endinterface
`default_nettype wire

/* rtl/tvs_axis.sv */
`timescale 1ns / 1ps
`default_nettype none
// Scales one axis and splits it into cell index and fraction (two stages).
module tvs_axis #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [tvs_pkg::POS_W-1:0] i_pos,
    input  wire logic [tvs_pkg::INV_W-1:0] i_inv,
    output logic signed [tvs_pkg::POS_W:0] o_cell,
    output logic [FRAC_BITS-1:0]           o_frac
);
    import tvs_pkg::*;
    localparam int unsigned PW = POS_W + INV_W + 1;
    localparam int unsigned SH = FRAC_BITS + INV_FRAC;

    logic signed [PW-1:0] r_prod;
    logic [PW-1:0]        w_mag;
    logic signed [PW-1:0] w_pos_ext;
    logic signed [PW-1:0] w_inv_ext;

    // Operands extended to the full product width.
    always_comb begin
        w_pos_ext = {{(PW-POS_W){i_pos[POS_W-1]}}, i_pos};
        w_inv_ext = {{(PW-INV_W){1'b0}}, i_inv};
    end

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_pos_ext * w_inv_ext;
        end
    end

    // Split stage: truncation toward zero, negative fraction clamps to zero.
    always_comb begin
        w_mag = r_prod[PW-1] ? (~r_prod + PW'(1)) : r_prod;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_prod[PW-1]) begin
                o_cell <= -$signed({1'b0, POS_W'(w_mag >> SH)});
                o_frac <= '0;
            end else begin
                o_cell <= $signed({1'b0, POS_W'(w_mag >> SH)});
                o_frac <= w_mag[SH-1:INV_FRAC];
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/tvs_lerp.sv */
`timescale 1ns / 1ps
`default_nettype none
// One registered blend: floor((a*(1-t) + b*t + half) / 2^F).
module tvs_lerp #(
    parameter int unsigned VW = 32,
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [VW-1:0] i_a,
    input  wire logic signed [VW-1:0] i_b,
    input  wire logic [FRAC_BITS-1:0] i_t,
    output logic signed [VW-1:0]      o_y
);
    localparam int unsigned SW = VW + FRAC_BITS + 2;
    localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
    logic signed [SW-1:0] w_ax;
    logic signed [SW-1:0] w_d;
    logic signed [SW-1:0] w_t;
    logic signed [SW-1:0] w_s;

    // a + (b-a)*t keeps one multiplier.
    always_comb begin
        w_ax = {{(SW-VW){i_a[VW-1]}}, i_a};
        w_d  = {{(SW-VW){i_b[VW-1]}}, i_b} - w_ax;
        w_t  = {{(SW-FRAC_BITS){1'b0}}, i_t};
        w_s  = (w_ax <<< FRAC_BITS) + w_d * w_t + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_y <= VW'(w_s >>> FRAC_BITS);
        end
    end
endmodule
`default_nettype wire

/* rtl/trilinear_volume_sample_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// A query result passes the axis, corner-address, bank-read and blend registers.
// One beat (write or query) per cycle while not stalled; a write gives no result.
// The eight corners are read from eight parity banks in parallel.
// Reset is synchronous, active low; it clears valid bits and resets the configuration.
// The sample store is not cleared; write samples before reading (not enforced).
module trilinear_volume_sample_top #(
    parameter int unsigned MAX_RES = 64,
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tvs_in_if.sink           i_in,
    tvs_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tvs_pkg::*;
    localparam int unsigned HW = $clog2(MAX_RES / 2 + 1);
    localparam int unsigned BD = (MAX_RES / 2 + 1) ** 3;
    localparam int unsigned BW = $clog2(BD);
    localparam int unsigned NS = 7;

    t_cfg r_cfg;
    logic [NS-1:0] r_vld;
    logic          w_en;

    // Stall the whole pipe only when the last stage holds an untaken beat.
    assign w_en = !(r_vld[NS-1] && !o_out.ready);
    assign i_in.ready = w_en;
    assign pready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_x <= INV_W'(65536);
            r_cfg.inv_y <= INV_W'(65536);
            r_cfg.inv_z <= INV_W'(65536);
            r_cfg.res_x <= RES_W'(64);
            r_cfg.res_y <= RES_W'(64);
            r_cfg.res_z <= RES_W'(64);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_INV_X: r_cfg.inv_x <= pwdata[INV_W-1:0];
                REG_INV_Y: r_cfg.inv_y <= pwdata[INV_W-1:0];
                REG_INV_Z: r_cfg.inv_z <= pwdata[INV_W-1:0];
                REG_RES_X: r_cfg.res_x <= pwdata[RES_W-1:0];
                REG_RES_Y: r_cfg.res_y <= pwdata[RES_W-1:0];
                REG_RES_Z: r_cfg.res_z <= pwdata[RES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_INV_X: prdata = 32'(r_cfg.inv_x);
            REG_INV_Y: prdata = 32'(r_cfg.inv_y);
            REG_INV_Z: prdata = 32'(r_cfg.inv_z);
            REG_RES_X: prdata = 32'(r_cfg.res_x);
            REG_RES_Y: prdata = 32'(r_cfg.res_y);
            REG_RES_Z: prdata = 32'(r_cfg.res_z);
            default:   prdata = '0;
        endcase
    end

    // Valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_in.valid && i_in.op == OP_QUERY};
        end
    end

    // Stages 1-2: axis scaling.
    logic signed [POS_W:0] w_cx, w_cy, w_cz;
    logic [FRAC_BITS-1:0]  w_u, w_v, w_w;
    tvs_axis #(.FRAC_BITS(FRAC_BITS)) u_ax (.i_clk, .i_en(w_en), .i_pos(i_in.pos_x),
        .i_inv(r_cfg.inv_x), .o_cell(w_cx), .o_frac(w_u));
    tvs_axis #(.FRAC_BITS(FRAC_BITS)) u_ay (.i_clk, .i_en(w_en), .i_pos(i_in.pos_y),
        .i_inv(r_cfg.inv_y), .o_cell(w_cy), .o_frac(w_v));
    tvs_axis #(.FRAC_BITS(FRAC_BITS)) u_az (.i_clk, .i_en(w_en), .i_pos(i_in.pos_z),
        .i_inv(r_cfg.inv_z), .o_cell(w_cz), .o_frac(w_w));

    // Write path: bank by index parity, half index as bank address.
    logic [HW-1:0] w_wh [3];
    logic [2:0]    w_wp;
    logic [BW-1:0] w_waddr;
    always_comb begin
        w_wp = {i_in.sample_z[0], i_in.sample_y[0], i_in.sample_x[0]};
        w_wh[0] = HW'(i_in.sample_x[IDX_W-1:1]);
        w_wh[1] = HW'(i_in.sample_y[IDX_W-1:1]);
        w_wh[2] = HW'(i_in.sample_z[IDX_W-1:1]);
        w_waddr = BW'(w_wh[0] + (MAX_RES/2+1) * (w_wh[1] + (MAX_RES/2+1) * w_wh[2]));
    end
    logic w_wok;
    assign w_wok = i_in.valid && w_en && i_in.op == OP_WRITE
        && 32'(i_in.sample_x) < MAX_RES && 32'(i_in.sample_y) < MAX_RES
        && 32'(i_in.sample_z) < MAX_RES;

    // A write travels with the pipe and reaches the banks at the read stage,
    // so every query sees exactly the writes accepted before it.
    logic [2:0]             r_wr_vld;
    logic [2:0]             r_wr_par [3];
    logic [BW-1:0]          r_wr_addr [3];
    logic [VALUE_WIDTH-1:0] r_wr_val [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_vld <= '0;
        end else if (w_en) begin
            r_wr_vld <= {r_wr_vld[1:0], w_wok};
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wr_par[0]  <= w_wp;
            r_wr_par[1]  <= r_wr_par[0];
            r_wr_par[2]  <= r_wr_par[1];
            r_wr_addr[0] <= w_waddr;
            r_wr_addr[1] <= r_wr_addr[0];
            r_wr_addr[2] <= r_wr_addr[1];
            r_wr_val[0]  <= i_in.sample_value;
            r_wr_val[1]  <= r_wr_val[0];
            r_wr_val[2]  <= r_wr_val[1];
        end
    end

    // Stage 3: corner bank addresses and in-range flags.
    logic [FRAC_BITS-1:0] r3_u, r3_v, r3_w;
    logic [BW-1:0]        w_raddr [8];
    logic [7:0]           w_ok;
    logic [BW-1:0]        r4_ra [8];
    logic [7:0]           r4_ok;
    logic [FRAC_BITS-1:0] r4_u, r4_v, r4_w;
    always_comb begin
        logic signed [POS_W+1:0] c [3];
        logic [RES_W:0] er [3];
        logic signed [POS_W+1:0] k [3];
        logic [HW-1:0] h [3];
        er[0] = (32'(r_cfg.res_x) > MAX_RES) ? (RES_W+1)'(MAX_RES) : {1'b0, r_cfg.res_x};
        er[1] = (32'(r_cfg.res_y) > MAX_RES) ? (RES_W+1)'(MAX_RES) : {1'b0, r_cfg.res_y};
        er[2] = (32'(r_cfg.res_z) > MAX_RES) ? (RES_W+1)'(MAX_RES) : {1'b0, r_cfg.res_z};
        c[0] = {w_cx[POS_W], w_cx};
        c[1] = {w_cy[POS_W], w_cy};
        c[2] = {w_cz[POS_W], w_cz};
        for (int n = 0; n < 8; n++) begin
            w_ok[n] = 1'b1;
            for (int a = 0; a < 3; a++) begin
                k[a] = c[a] + (POS_W+2)'((n >> a) & 1);
                if (k[a] < 0 || k[a] >= $signed({1'b0, (POS_W+1)'(er[a])})) w_ok[n] = 1'b0;
                h[a] = HW'(k[a] >>> 1);
            end
            w_raddr[n] = BW'(h[0] + (MAX_RES/2+1) * (h[1] + (MAX_RES/2+1) * h[2]));
        end
    end

    // Corner n has bit a = offset on axis a; its bank parity = cell parity ^ offset.
    logic [2:0] w_par, r4_par;
    assign w_par = {w_cz[0], w_cy[0], w_cx[0]};
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ra  <= w_raddr;
            r4_ok  <= w_ok;
            r4_par <= w_par;
            r4_u <= w_u; r4_v <= w_v; r4_w <= w_w;
        end
    end

    // Stage 4: eight banks, registered read.
    logic [VALUE_WIDTH-1:0] w_rd [8];
    logic [7:0]             r5_ok;
    logic [2:0]             r5_par;
    for (genvar g = 0; g < 8; g++) begin : g_bank
        logic [VALUE_WIDTH-1:0] r_mem [BD];
        logic [VALUE_WIDTH-1:0] r_rd;
        logic [BW-1:0]          w_ba;
        always_comb begin
            w_ba = '0;
            for (int n = 0; n < 8; n++)
                if ((r4_par ^ 3'(n)) == 3'(g)) w_ba = r4_ra[n];
        end
        always_ff @(posedge i_clk) begin
            if (w_en && r_wr_vld[2] && r_wr_par[2] == 3'(g)) r_mem[r_wr_addr[2]] <= r_wr_val[2];
            if (w_en) r_rd <= r_mem[w_ba];
        end
        assign w_rd[g] = r_rd;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_ok <= r4_ok; r5_par <= r4_par;
            r3_u <= r4_u; r3_v <= r4_v; r3_w <= r4_w;
        end
    end

    // Corner routing back from banks.
    logic signed [VALUE_WIDTH-1:0] w_c [8];
    always_comb begin
        for (int n = 0; n < 8; n++)
            w_c[n] = r5_ok[n] ? $signed(w_rd[r5_par ^ 3'(n)]) : '0;
    end

    // Stages 5-7: x, y, z blends. Widths grow to hold the rounded range.
    localparam int unsigned XW = VALUE_WIDTH + 2;
    logic signed [XW-1:0] w_a [4];
    logic signed [XW-1:0] w_b [2];
    logic signed [XW-1:0] w_r;
    logic [FRAC_BITS-1:0] r6_v, r6_w, r7_w;
    for (genvar g = 0; g < 4; g++) begin : g_x
        tvs_lerp #(.VW(XW), .FRAC_BITS(FRAC_BITS)) u_l (.i_clk, .i_en(w_en),
            .i_a(XW'(w_c[2*g])), .i_b(XW'(w_c[2*g+1])), .i_t(r3_u), .o_y(w_a[g]));
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_v <= r3_v; r6_w <= r3_w; r7_w <= r6_w;
        end
    end
    tvs_lerp #(.VW(XW), .FRAC_BITS(FRAC_BITS)) u_y0 (.i_clk, .i_en(w_en),
        .i_a(w_a[0]), .i_b(w_a[1]), .i_t(r6_v), .o_y(w_b[0]));
    tvs_lerp #(.VW(XW), .FRAC_BITS(FRAC_BITS)) u_y1 (.i_clk, .i_en(w_en),
        .i_a(w_a[2]), .i_b(w_a[3]), .i_t(r6_v), .o_y(w_b[1]));
    tvs_lerp #(.VW(XW), .FRAC_BITS(FRAC_BITS)) u_z (.i_clk, .i_en(w_en),
        .i_a(w_b[0]), .i_b(w_b[1]), .i_t(r7_w), .o_y(w_r));

    // Saturate to the value width.
    localparam logic signed [XW-1:0] HI = XW'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    localparam logic signed [XW-1:0] LO = -HI - XW'(1);
    logic signed [XW-1:0] w_sat;
    always_comb begin
        if (w_r > HI) w_sat = HI;
        else if (w_r < LO) w_sat = LO;
        else w_sat = w_r;
    end
    assign o_out.valid = r_vld[NS-1];
    assign o_out.interp_value = 32'(w_sat[VALUE_WIDTH-1:0]);
endmodule
`default_nettype wire
